### src/media_packet_header_resync_assert.svh
// assertion macros for the packet resync block
`ifndef MEDIA_PACKET_HEADER_RESYNC_ASSERT_SVH
`define MEDIA_PACKET_HEADER_RESYNC_ASSERT_SVH

// same-cycle implication
`define MPHR_ASSERT_IMP(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// next-cycle implication
`define MPHR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

### src/mphr_pkg.sv
package mphr_pkg;

    localparam int BYTE_W       = 8;
    localparam int WINDOW_W     = 32;
    localparam int STREAM_W     = 16;
    localparam int TIME_W       = 32;
    localparam int LENGTH_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int COUNT_W      = 3;

    localparam int MAX_STREAMS_DEF = 4;
    localparam int NUM_ID_REGS     = 4;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'hFFFF_FFFF;
    localparam logic [WINDOW_W-1:0] INDEX_TAG    = 32'h494E_4458;
    localparam logic [LENGTH_W-1:0] MIN_PKT_LEN  = 16'd12;
    localparam logic [LENGTH_W-1:0] INDEX_HDR_LEN = 16'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID_A  = 3'd1;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic                 item_kind;
        logic [STREAM_W-1:0]  packet_stream;
        logic [TIME_W-1:0]    packet_time;
        logic [BYTE_W-1:0]    packet_flags;
        logic [LENGTH_W-1:0]  payload_length;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 last_of_packet;
    } t_result;

endpackage

### src/media_packet_header_resync.sv
// channel  | handshake                      | payload
// in       | i_in_valid / o_in_stall        | i_in_data_byte
// out      | o_out_valid / i_out_stall      | o_out_item_kind .. o_out_last_of_packet
// cfg      | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one byte per clock while the input is not stalled; each byte is parsed in
// the cycle it is accepted and its result, if any, is registered in the buffer
// a two-entry output buffer (result register plus skid) sets the stall:
// input stalls only while both entries hold results
// synchronous active-low reset; config is always ready
`include "media_packet_header_resync_assert.svh"

module media_packet_header_resync
    import mphr_pkg::*;
#(
    parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_in_data_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_out_item_kind,
    output logic [STREAM_W-1:0]    o_out_packet_stream,
    output logic [TIME_W-1:0]      o_out_packet_time,
    output logic [BYTE_W-1:0]      o_out_packet_flags,
    output logic [LENGTH_W-1:0]    o_out_payload_length,
    output logic [BYTE_W-1:0]      o_out_payload_byte,
    output logic                   o_out_last_of_packet,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NUM_IDS = (MAX_STREAMS < NUM_ID_REGS) ? MAX_STREAMS : NUM_ID_REGS;

    typedef enum logic [3:0] {
        PH_SCAN, PH_IDX_HI, PH_IDX_LO, PH_SKIP, PH_ID_HI, PH_ID_LO,
        PH_T0, PH_T1, PH_T2, PH_T3, PH_RSV, PH_FLG, PH_PAY
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [WINDOW_W-1:0]   r_window, n_window;
    logic [LENGTH_W-1:0]   r_remaining, n_remaining;
    logic [STREAM_W-1:0]   r_stream, n_stream;
    logic [TIME_W-1:0]     r_time, n_time;
    logic [BYTE_W-1:0]     r_flags, n_flags;
    logic [LENGTH_W-1:0]   r_length, n_length;
    logic [BYTE_W-1:0]     r_idx_hi, n_idx_hi;

    logic [COUNT_W-1:0]    r_stream_count;
    logic [STREAM_W-1:0]   r_stream_ids [NUM_IDS];

    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_skid_valid;
    t_result               r_skid;

    logic                  in_accept;
    logic                  out_free;
    logic                  res_valid;
    t_result               res;
    logic [WINDOW_W-1:0]   shifted;
    logic [LENGTH_W-1:0]   idx_len;
    logic [LENGTH_W-1:0]   rem_dec;
    logic                  known;
    logic                  counting;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        known = 1'b0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (COUNT_W'(i) < r_stream_count && r_stream_ids[i] == r_stream) begin
                known = 1'b1;
            end
        end
    end

    assign shifted  = {r_window[WINDOW_W-BYTE_W-1:0], i_in_data_byte};
    assign idx_len  = {r_idx_hi, i_in_data_byte};
    assign rem_dec  = (r_remaining != '0) ? r_remaining - 16'd1 : '0;
    assign counting = (r_phase == PH_SKIP) || (r_phase == PH_PAY);

    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_remaining = r_remaining;
        n_stream    = r_stream;
        n_time      = r_time;
        n_flags     = r_flags;
        n_length    = r_length;
        n_idx_hi    = r_idx_hi;
        res_valid   = 1'b0;
        res.item_kind      = KIND_HEADER;
        res.packet_stream  = r_stream;
        res.packet_time    = r_time;
        res.packet_flags   = r_flags;
        res.payload_length = r_length;
        res.payload_byte   = '0;
        res.last_of_packet = 1'b0;
        unique case (r_phase)
            PH_SCAN: begin
                n_window = shifted;
                if (shifted == INDEX_TAG) begin
                    n_phase = PH_IDX_HI;
                end else if (shifted[WINDOW_W-1:LENGTH_W] == '0
                             && shifted[LENGTH_W-1:0] >= MIN_PKT_LEN) begin
                    n_length = shifted[LENGTH_W-1:0] - MIN_PKT_LEN;
                    n_window = WINDOW_RESET;
                    n_phase  = PH_ID_HI;
                end
            end
            PH_IDX_HI: begin
                n_idx_hi = i_in_data_byte;
                n_phase  = PH_IDX_LO;
            end
            PH_IDX_LO: begin
                if (idx_len > INDEX_HDR_LEN) begin
                    n_remaining = idx_len - INDEX_HDR_LEN;
                    n_phase     = PH_SKIP;
                end else begin
                    n_phase = PH_SCAN;
                end
            end
            PH_SKIP: begin
                n_remaining = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_SCAN;
                end
            end
            PH_ID_HI: begin
                n_stream = {i_in_data_byte, 8'h00};
                n_phase  = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_stream = {r_stream[STREAM_W-1:BYTE_W], i_in_data_byte};
                n_phase  = PH_T0;
            end
            PH_T0: begin
                n_time  = {r_time[TIME_W-BYTE_W-1:0], i_in_data_byte};
                n_phase = PH_T1;
            end
            PH_T1: begin
                n_time  = {r_time[TIME_W-BYTE_W-1:0], i_in_data_byte};
                n_phase = PH_T2;
            end
            PH_T2: begin
                n_time  = {r_time[TIME_W-BYTE_W-1:0], i_in_data_byte};
                n_phase = PH_T3;
            end
            PH_T3: begin
                n_time  = {r_time[TIME_W-BYTE_W-1:0], i_in_data_byte};
                n_phase = PH_RSV;
            end
            PH_RSV: begin
                n_phase = PH_FLG;
            end
            PH_FLG: begin
                n_flags     = i_in_data_byte;
                n_remaining = r_length;
                if (known) begin
                    n_phase            = (r_length != '0) ? PH_PAY : PH_SCAN;
                    res_valid          = 1'b1;
                    res.packet_flags   = i_in_data_byte;
                    res.last_of_packet = (r_length == '0);
                end else begin
                    n_phase = (r_length != '0) ? PH_SKIP : PH_SCAN;
                end
            end
            PH_PAY: begin
                n_remaining = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = PH_SCAN;
                end
                res_valid          = 1'b1;
                res.item_kind      = KIND_PAYLOAD;
                res.payload_byte   = i_in_data_byte;
                res.last_of_packet = (rem_dec == '0);
            end
            default: begin
                n_phase = PH_SCAN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SCAN;
            r_window       <= WINDOW_RESET;
            r_remaining    <= '0;
            r_stream_count <= '0;
            for (int i = 0; i < NUM_IDS; i++) begin
                r_stream_ids[i] <= '0;
            end
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_STREAM_COUNT) begin
                    r_stream_count <= i_cfg_data[COUNT_W-1:0];
                end
                for (int i = 0; i < NUM_IDS; i++) begin
                    if (i_cfg_index == CFG_STREAM_ID_A + CFG_IDX_W'(i)) begin
                        r_stream_ids[i] <= i_cfg_data[STREAM_W-1:0];
                    end
                end
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_window    <= n_window;
                r_remaining <= n_remaining;
                r_stream    <= n_stream;
                r_time      <= n_time;
                r_flags     <= n_flags;
                r_length    <= n_length;
                r_idx_hi    <= n_idx_hi;
            end
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (in_accept && res_valid) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_accept && res_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_item_kind      = r_out.item_kind;
    assign o_out_packet_stream  = r_out.packet_stream;
    assign o_out_packet_time    = r_out.packet_time;
    assign o_out_packet_flags   = r_out.packet_flags;
    assign o_out_payload_length = r_out.payload_length;
    assign o_out_payload_byte   = r_out.payload_byte;
    assign o_out_last_of_packet = r_out.last_of_packet;

    `MPHR_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `MPHR_ASSERT_IMP(a_count_live, i_clk, i_rst_n, counting, r_remaining != '0)
    `MPHR_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall, !r_skid_valid)

endmodule

### tb/resync_checker.sv
`timescale 1ns / 1ps

module resync_checker
    import mphr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [BYTE_W-1:0]      i_in_data_byte,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_out_item_kind,
    input  logic [STREAM_W-1:0]    i_out_packet_stream,
    input  logic [TIME_W-1:0]      i_out_packet_time,
    input  logic [BYTE_W-1:0]      i_out_packet_flags,
    input  logic [LENGTH_W-1:0]    i_out_payload_length,
    input  logic [BYTE_W-1:0]      i_out_payload_byte,
    input  logic                   i_out_last_of_packet,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    typedef enum logic [3:0] {
        ST_SCAN,
        ST_INDEX_MSB,
        ST_INDEX_LSB,
        ST_SKIP,
        ST_ID_MSB,
        ST_ID_LSB,
        ST_TIME0,
        ST_TIME1,
        ST_TIME2,
        ST_TIME3,
        ST_RESERVED,
        ST_FLAGS,
        ST_PAYLOAD
    } parse_step_e;

    logic [COUNT_W-1:0]  known_count;
    logic [STREAM_W-1:0] known_ids [NUM_ID_REGS];

    logic [WINDOW_W-1:0] scan_window;
    parse_step_e         parse_step;
    logic [LENGTH_W-1:0] skip_left;
    logic [STREAM_W-1:0] hdr_stream;
    logic [TIME_W-1:0]   hdr_time;
    logic [BYTE_W-1:0]   hdr_flags;
    logic [LENGTH_W-1:0] hdr_payload_len;
    logic [BYTE_W-1:0]   index_len_msb;

    t_result awaited_items [$];
    t_result want;
    int      mismatches = 0;

    task automatic await_result(input logic kind, input logic [BYTE_W-1:0] data);
        t_result r;
        r.item_kind      = kind;
        r.packet_stream  = hdr_stream;
        r.packet_time    = hdr_time;
        r.packet_flags   = hdr_flags;
        r.payload_length = hdr_payload_len;
        r.payload_byte   = data;
        r.last_of_packet = (skip_left == 0);
        awaited_items.push_back(r);
    endtask

    task automatic parse_container_byte(input logic [BYTE_W-1:0] b);
        logic [LENGTH_W-1:0] index_len;
        int                  live;
        logic                known;
        case (parse_step)
            ST_SCAN: begin
                scan_window = {scan_window[WINDOW_W-9:0], b};
                if (scan_window == INDEX_TAG) begin
                    parse_step = ST_INDEX_MSB;
                end else if (scan_window >= WINDOW_W'(MIN_PKT_LEN)
                             && scan_window <= 32'h0000_FFFF) begin
                    hdr_payload_len = scan_window[LENGTH_W-1:0] - MIN_PKT_LEN;
                    scan_window     = WINDOW_RESET;
                    parse_step      = ST_ID_MSB;
                end
            end
            ST_INDEX_MSB: begin
                index_len_msb = b;
                parse_step    = ST_INDEX_LSB;
            end
            ST_INDEX_LSB: begin
                index_len = {index_len_msb, b};
                if (index_len > INDEX_HDR_LEN) begin
                    skip_left  = index_len - INDEX_HDR_LEN;
                    parse_step = ST_SKIP;
                end else begin
                    parse_step = ST_SCAN;
                end
            end
            ST_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) parse_step = ST_SCAN;
            end
            ST_ID_MSB: begin
                hdr_stream = {b, 8'h00};
                parse_step = ST_ID_LSB;
            end
            ST_ID_LSB: begin
                hdr_stream[7:0] = b;
                parse_step      = ST_TIME0;
            end
            ST_TIME0, ST_TIME1, ST_TIME2, ST_TIME3: begin
                hdr_time   = {hdr_time[TIME_W-9:0], b};
                parse_step = parse_step_e'(parse_step + 1);
            end
            ST_RESERVED: begin
                parse_step = ST_FLAGS;
            end
            ST_FLAGS: begin
                hdr_flags = b;
                skip_left = hdr_payload_len;
                live = (known_count > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : known_count;
                if (live > NUM_ID_REGS) live = NUM_ID_REGS;
                known = 1'b0;
                for (int k = 0; k < live; k++) begin
                    if (known_ids[k] == hdr_stream) known = 1'b1;
                end
                if (!known) begin
                    parse_step = (skip_left != 0) ? ST_SKIP : ST_SCAN;
                end else begin
                    parse_step = (skip_left != 0) ? ST_PAYLOAD : ST_SCAN;
                    await_result(KIND_HEADER, 8'h00);
                end
            end
            ST_PAYLOAD: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) parse_step = ST_SCAN;
                await_result(KIND_PAYLOAD, b);
            end
            default: begin
                parse_step = ST_SCAN;
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] exp_val,
                                 input logic [TIME_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            known_count     = '0;
            foreach (known_ids[k]) known_ids[k] = '0;
            scan_window     = WINDOW_RESET;
            parse_step      = ST_SCAN;
            skip_left       = '0;
            hdr_stream      = '0;
            hdr_time        = '0;
            hdr_flags       = '0;
            hdr_payload_len = '0;
            index_len_msb   = '0;
            awaited_items.delete();
        end else begin
            // results are registered after their byte, so compare before predicting
            if (i_out_valid && !i_out_stall) begin
                if (awaited_items.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %0d %0h %0h %0d",
                             $time, i_out_item_kind, i_out_packet_stream,
                             i_out_payload_byte, i_out_last_of_packet);
                    mismatches++;
                end else begin
                    want = awaited_items.pop_front();
                    compare_field("item_kind", TIME_W'(want.item_kind),
                                  TIME_W'(i_out_item_kind));
                    compare_field("packet_stream", TIME_W'(want.packet_stream),
                                  TIME_W'(i_out_packet_stream));
                    compare_field("packet_time", want.packet_time, i_out_packet_time);
                    compare_field("packet_flags", TIME_W'(want.packet_flags),
                                  TIME_W'(i_out_packet_flags));
                    compare_field("payload_length", TIME_W'(want.payload_length),
                                  TIME_W'(i_out_payload_length));
                    compare_field("payload_byte", TIME_W'(want.payload_byte),
                                  TIME_W'(i_out_payload_byte));
                    compare_field("last_of_packet", TIME_W'(want.last_of_packet),
                                  TIME_W'(i_out_last_of_packet));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_STREAM_COUNT) begin
                    known_count = i_cfg_data[COUNT_W-1:0];
                end else if (i_cfg_index >= CFG_STREAM_ID_A
                             && i_cfg_index < CFG_STREAM_ID_A + NUM_ID_REGS) begin
                    known_ids[2'(i_cfg_index - CFG_STREAM_ID_A)] = i_cfg_data[STREAM_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) parse_container_byte(i_in_data_byte);
        end
        o_pending <= awaited_items.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mphr_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  out_kind;
    logic [STREAM_W-1:0]   out_stream;
    logic [TIME_W-1:0]     out_time;
    logic [BYTE_W-1:0]     out_flags;
    logic [LENGTH_W-1:0]   out_length;
    logic [BYTE_W-1:0]     out_byte;
    logic                  out_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;

    logic [COUNT_W-1:0]  live_count = '0;
    logic [STREAM_W-1:0] live_ids [NUM_ID_REGS];

    always #1 clk = ~clk;

    media_packet_header_resync uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (in_stall),
        .i_in_data_byte       (in_data),
        .o_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .o_out_item_kind      (out_kind),
        .o_out_packet_stream  (out_stream),
        .o_out_packet_time    (out_time),
        .o_out_packet_flags   (out_flags),
        .o_out_payload_length (out_length),
        .o_out_payload_byte   (out_byte),
        .o_out_last_of_packet (out_last),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    resync_checker result_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_stall           (in_stall),
        .i_in_data_byte       (in_data),
        .i_out_valid          (out_valid),
        .i_out_stall          (out_stall),
        .i_out_item_kind      (out_kind),
        .i_out_packet_stream  (out_stream),
        .i_out_packet_time    (out_time),
        .i_out_packet_flags   (out_flags),
        .i_out_payload_length (out_length),
        .i_out_payload_byte   (out_byte),
        .i_out_last_of_packet (out_last),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .o_errors             (errors),
        .o_pending            (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        in_idle_pct = sender_pct;
        out_stall_pct <= receiver_pct;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [LENGTH_W-1:0] len, input logic [STREAM_W-1:0] id,
                               input logic [TIME_W-1:0] stamp, input logic [BYTE_W-1:0] flags,
                               input logic [BYTE_W-1:0] rsv);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(id[15:8]);
        send_byte(id[7:0]);
        for (int k = 3; k >= 0; k--) send_byte(stamp[8*k +: 8]);
        send_byte(rsv);
        send_byte(flags);
        if (len > MIN_PKT_LEN) repeat (len - MIN_PKT_LEN) send_byte(8'($urandom));
    endtask

    task automatic send_index(input logic [LENGTH_W-1:0] len);
        for (int k = 3; k >= 0; k--) send_byte(INDEX_TAG[8*k +: 8]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len > INDEX_HDR_LEN) repeat (len - INDEX_HDR_LEN) send_byte(8'($urandom));
    endtask

    task automatic send_random(input int n_items);
        int                  stop_at;
        int                  pick;
        int                  live;
        int                  len;
        logic [STREAM_W-1:0] id;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                live = (live_count > MAX_STREAMS_DEF) ? MAX_STREAMS_DEF : live_count;
                if (live > 0 && $urandom_range(0, 3) != 0) begin
                    id = live_ids[$urandom_range(0, live - 1)];
                end else begin
                    id = STREAM_W'($urandom);
                end
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    len = MIN_PKT_LEN;
                end else if (pick < 3) begin
                    // too short to be a length, the rest is scanned as noise
                    len = $urandom_range(0, MIN_PKT_LEN - 1);
                end else begin
                    len = $urandom_range(MIN_PKT_LEN + 1, 36);
                end
                send_packet(LENGTH_W'(len), id, $urandom, BYTE_W'($urandom), BYTE_W'($urandom));
            end else if (pick < 80) begin
                send_index(LENGTH_W'($urandom_range(0, 14)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
            end
        end
    endtask

    task automatic write_streams(input logic [COUNT_W-1:0] count,
                                 input logic [STREAM_W-1:0] id_a, input logic [STREAM_W-1:0] id_b,
                                 input logic [STREAM_W-1:0] id_c, input logic [STREAM_W-1:0] id_d);
        logic [STREAM_W-1:0] ids [NUM_ID_REGS];
        ids = '{id_a, id_b, id_c, id_d};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_STREAM_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        for (int k = 0; k < NUM_ID_REGS; k++) begin
            cfg_index <= CFG_STREAM_ID_A + CFG_IDX_W'(k);
            cfg_data  <= ids[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        live_count = count;
        live_ids   = ids;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count above the number of id registers
        write_streams(3'd7, 16'h0000, 16'hFFFF, 16'h1234, 16'hABCD);
        set_idling(26, 84);
        // empty payload, short index length, zero skip
        send_packet(MIN_PKT_LEN, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00);
        send_index(16'd3);
        send_index(INDEX_HDR_LEN);
        send_random(130);
        settle();

        write_streams(3'd3, STREAM_W'($urandom), STREAM_W'($urandom), STREAM_W'($urandom),
                      STREAM_W'($urandom));
        set_idling(84, 26);
        send_random(130);
        settle();

        // no known streams, every packet skipped
        write_streams(3'd0, live_ids[0], live_ids[1], live_ids[2], live_ids[3]);
        set_idling(0, 0);
        send_random(40);
        settle();

        write_streams(3'd4, STREAM_W'($urandom), STREAM_W'($urandom), STREAM_W'($urandom),
                      STREAM_W'($urandom));
        send_random(100);
        settle();

        @(negedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
